/* rtl/sha1mh_pkg.sv */
// Shared types, constants and functions of the SHA-1 message hasher.
`default_nettype none

package sha1mh_pkg;

  localparam int unsigned BLK_WORDS = 16;
  localparam int unsigned DIG_WORDS = 5;
  localparam int unsigned ROUNDS    = 80;

  // Padding: 0x80 marker byte, length field starts at bit 448 of the block.
  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [3:0] LEN_HI_IDX = 4'(448 / 32);
  localparam logic [3:0] LEN_LO_IDX = 4'(448 / 32 + 1);
  localparam logic [3:0] LAST_WIDX  = 4'(BLK_WORDS - 1);

  localparam logic [6:0] LAST_RND   = 7'(ROUNDS - 1);
  localparam logic [2:0] LAST_DIG   = 3'(DIG_WORDS - 1);
  localparam logic [2:0] NUM_DIG    = 3'(DIG_WORDS);

  localparam logic [31:0] K0 = 32'h5A82_7999;
  localparam logic [31:0] K1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K3 = 32'hCA62_C1D6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAD,
    ST_ZERO,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_DIG_RD,
    ST_DIG_OUT
  } state_e;

  // Control from the sequencer to the compression core.
  typedef struct packed {
    logic       sched_we;
    logic       sched_re;
    logic [3:0] sched_addr;
    logic       var_push;
    logic       round_en;
    logic [6:0] rnd;
  } core_ctrl_t;

  // Initial chaining value of one digest word.
  function automatic logic [31:0] chain_iv(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = 32'h6745_2301;
      3'd1:    v = 32'hEFCD_AB89;
      3'd2:    v = 32'h98BA_DCFE;
      3'd3:    v = 32'h1032_5476;
      3'd4:    v = 32'hC3D2_E1F0;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/sha1mh_packer.sv */
// Byte packer: merges message bytes into big-endian 32-bit block words.
`default_nettype none

module sha1mh_packer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        take_i,
  input  wire logic        clear_i,
  input  wire logic [31:0] word_i,
  input  wire logic [2:0]  nbytes_i,
  output logic [31:0]      merged_o,
  output logic             full_o,
  output logic [31:0]      pad_word_o
);

  logic [31:0] acc_q, acc_d;
  logic [1:0]  acc_n_q, acc_n_d;
  logic [31:0] acc_m, word_m;
  logic [63:0] cat;
  logic [3:0]  total;

  // Keep the top n bytes of a word.
  function automatic logic [31:0] top_mask(input logic [2:0] n);
    logic [31:0] m;
    case (n)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'hFF00_0000;
      3'd2:    m = 32'hFFFF_0000;
      3'd3:    m = 32'hFFFF_FF00;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  always_comb begin
    acc_m  = acc_q & top_mask({1'b0, acc_n_q});
    word_m = word_i & top_mask(nbytes_i);
    cat    = {acc_m, 32'h0} | ({word_m, 32'h0} >> {acc_n_q, 3'b000});
    total  = {2'b00, acc_n_q} + {1'b0, nbytes_i};
    full_o = total[3] | total[2];
    merged_o   = cat[63:32];
    pad_word_o = acc_m | ({sha1mh_pkg::PAD_BYTE, 24'h0} >> {acc_n_q, 3'b000});

    acc_d   = acc_q;
    acc_n_d = acc_n_q;
    if (clear_i) begin
      acc_n_d = 2'd0;
    end else if (take_i) begin
      if (full_o) begin
        acc_d   = cat[31:0];
        acc_n_d = 2'(total - 4'd4);
      end else begin
        acc_d   = cat[63:32];
        acc_n_d = total[1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_n_q <= 2'd0;
    end else begin
      acc_n_q <= acc_n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

endmodule

`default_nettype wire

/* rtl/sha1mh_core.sv */
// Compression core: block word memory, schedule shift line, working variables, round.
`default_nettype none

module sha1mh_core (
  input  wire logic                   clk_i,
  input  wire sha1mh_pkg::core_ctrl_t ctrl_i,
  input  wire logic [31:0]            sched_wdata_i,
  input  wire logic [31:0]            push_data_i,
  output logic [31:0]                 var0_o
);

  logic [31:0] sched_mem_q [sha1mh_pkg::BLK_WORDS];
  logic [31:0] sched_rd_q;
  logic [31:0] w_q [sha1mh_pkg::BLK_WORDS];
  logic [31:0] var_q [sha1mh_pkg::DIG_WORDS];
  logic [31:0] w_t, w_x, f, k, tmp;

  // Block word memory, one port, registered read.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.sched_we) begin
      sched_mem_q[ctrl_i.sched_addr] <= sched_wdata_i;
    end
    if (ctrl_i.sched_re) begin
      sched_rd_q <= sched_mem_q[ctrl_i.sched_addr];
    end
  end

  always_comb begin
    // w_q[15] holds W[t-1], w_q[0] holds W[t-16].
    w_x = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    w_t = (ctrl_i.rnd < 7'd16) ? sched_rd_q : {w_x[30:0], w_x[31]};
    if (ctrl_i.rnd < 7'd20) begin
      f = (var_q[1] & var_q[2]) | (~var_q[1] & var_q[3]);
      k = sha1mh_pkg::K0;
    end else if (ctrl_i.rnd < 7'd40) begin
      f = var_q[1] ^ var_q[2] ^ var_q[3];
      k = sha1mh_pkg::K1;
    end else if (ctrl_i.rnd < 7'd60) begin
      f = (var_q[1] & var_q[2]) | (var_q[1] & var_q[3]) | (var_q[2] & var_q[3]);
      k = sha1mh_pkg::K2;
    end else begin
      f = var_q[1] ^ var_q[2] ^ var_q[3];
      k = sha1mh_pkg::K3;
    end
    tmp = {var_q[0][26:0], var_q[0][31:27]} + f + var_q[4] + k + w_t;
  end

  assign var0_o = var_q[0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.round_en) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15]  <= w_t;
      var_q[0] <= tmp;
      var_q[1] <= var_q[0];
      var_q[2] <= {var_q[1][1:0], var_q[1][31:2]};
      var_q[3] <= var_q[2];
      var_q[4] <= var_q[3];
    end else if (ctrl_i.var_push) begin
      // Shift toward var 0; load chaining values at the far end.
      for (int i = 0; i < 4; i++) begin
        var_q[i] <= var_q[i+1];
      end
      var_q[4] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/sha1_message_hasher_top.sv */
// Top level of the SHA-1 message hasher: sequencer, chaining memory, output stage.
//
// Input stream (s_axis): one message word per transfer. tdata[31:0] carries up
// to four bytes, first byte in bits 31:24; tdata[34:32] the count of leading
// valid bytes (counts above 4 act as 4). tlast marks the final word, which may
// hold 0 to 4 bytes and starts padding and digest output.
// Output stream (m_axis): five transfers per message, digest word 0 (most
// significant) first. tdata[31:0] is the word, tdata[34:32] its index; tlast is
// set on the fifth.
// A word that completes a 16-word block starts a compression: the chaining
// values are loaded from memory, 80 rounds run at one per cycle, then the
// values are read, added and written back. At message end the padding adds
// one or two compressions, then each digest word is read out through the
// chaining memory read port.
// The input is ready only while the sequencer is idle. A stalled output holds
// its word in the output register and the sequencer waits on it. After the
// fifth word is loaded, the chaining values return to the initial constants and
// the bit count to zero. Reset does the same at once and needs no clearing pass.
`default_nettype none

module sha1_message_hasher_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,  // [31:0] message_word, [34:32] bytes_valid
  input  wire logic        s_axis_tlast_i,  // end_of_message
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,  // [31:0] digest_word, [34:32] word_index
  output logic             m_axis_tlast_o   // last_word
);

  sha1mh_pkg::state_e     state_q, state_d, ret_q, ret_d;
  sha1mh_pkg::core_ctrl_t ctrl;

  logic [3:0]  widx_q, widx_d;
  logic [2:0]  cnt_q, cnt_d, cnt_m1;
  logic [6:0]  rnd_q, rnd_d;
  logic        fresh_q, fresh_d;
  logic [63:0] bitcnt_q, bitcnt_d;
  logic        ov_q, ov_d;
  logic [31:0] odata_q, odata_d;
  logic [2:0]  oidx_q, oidx_d;
  logic        olast_q, olast_d;

  // Chaining value memory.
  logic [31:0] chain_mem_q [sha1mh_pkg::DIG_WORDS];
  logic [31:0] ch_rd_q, ch_wdata, chain_val;
  logic        ch_we, ch_re;
  logic [2:0]  ch_waddr, ch_raddr;

  logic        s_fire;
  logic [2:0]  nbytes;
  logic        pk_take, pk_clear, pk_full;
  logic [31:0] pk_merged, pk_pad, sched_wdata, var0;

  assign nbytes = (s_axis_tdata_i[34:32] > 3'd4) ? 3'd4 : s_axis_tdata_i[34:32];
  assign s_axis_tready_o = (state_q == sha1mh_pkg::ST_IDLE);
  assign s_fire = s_axis_tvalid_i & s_axis_tready_o;
  assign cnt_m1 = 3'(cnt_q - 3'd1);

  // Until the first compression of a message writes back, the memory
  // contents stand for the initial constants.
  assign chain_val = fresh_q ? sha1mh_pkg::chain_iv(cnt_m1) : ch_rd_q;

  sha1mh_packer u_packer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (pk_take),
    .clear_i    (pk_clear),
    .word_i     (s_axis_tdata_i[31:0]),
    .nbytes_i   (nbytes),
    .merged_o   (pk_merged),
    .full_o     (pk_full),
    .pad_word_o (pk_pad)
  );

  sha1mh_core u_core (
    .clk_i         (clk_i),
    .ctrl_i        (ctrl),
    .sched_wdata_i (sched_wdata),
    .push_data_i   (chain_val),
    .var0_o        (var0)
  );

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    widx_d   = widx_q;
    cnt_d    = cnt_q;
    rnd_d    = rnd_q;
    fresh_d  = fresh_q;
    bitcnt_d = bitcnt_q;
    odata_d  = odata_q;
    oidx_d   = oidx_q;
    olast_d  = olast_q;
    ov_d     = ov_q & ~m_axis_tready_i;

    ctrl            = '0;
    ctrl.sched_addr = widx_q;
    ctrl.rnd        = rnd_q;
    sched_wdata     = 32'h0;
    pk_take         = 1'b0;
    pk_clear        = 1'b0;
    ch_we           = 1'b0;
    ch_re           = 1'b0;
    ch_waddr        = cnt_m1;
    ch_raddr        = cnt_q;
    ch_wdata        = chain_val + var0;

    case (state_q)
      sha1mh_pkg::ST_IDLE: begin
        if (s_fire) begin
          pk_take  = 1'b1;
          bitcnt_d = bitcnt_q + {58'h0, nbytes, 3'b000};
          state_d  = s_axis_tlast_i ? sha1mh_pkg::ST_PAD : sha1mh_pkg::ST_IDLE;
          if (pk_full) begin
            ctrl.sched_we = 1'b1;
            sched_wdata   = pk_merged;
            if (widx_q == sha1mh_pkg::LAST_WIDX) begin
              widx_d  = 4'd0;
              cnt_d   = 3'd0;
              ret_d   = state_d;
              state_d = sha1mh_pkg::ST_LOAD;
            end else begin
              widx_d = widx_q + 4'd1;
            end
          end
        end
      end
      sha1mh_pkg::ST_PAD: begin
        ctrl.sched_we = 1'b1;
        sched_wdata   = pk_pad;
        pk_clear      = 1'b1;
        if (widx_q == sha1mh_pkg::LAST_WIDX) begin
          widx_d  = 4'd0;
          cnt_d   = 3'd0;
          ret_d   = sha1mh_pkg::ST_ZERO;
          state_d = sha1mh_pkg::ST_LOAD;
        end else begin
          widx_d  = widx_q + 4'd1;
          state_d = sha1mh_pkg::ST_ZERO;
        end
      end
      sha1mh_pkg::ST_ZERO: begin
        if (widx_q == sha1mh_pkg::LEN_HI_IDX) begin
          state_d = sha1mh_pkg::ST_LEN_HI;
        end else begin
          ctrl.sched_we = 1'b1;
          if (widx_q == sha1mh_pkg::LAST_WIDX) begin
            widx_d  = 4'd0;
            cnt_d   = 3'd0;
            ret_d   = sha1mh_pkg::ST_ZERO;
            state_d = sha1mh_pkg::ST_LOAD;
          end else begin
            widx_d = widx_q + 4'd1;
          end
        end
      end
      sha1mh_pkg::ST_LEN_HI: begin
        ctrl.sched_we = 1'b1;
        sched_wdata   = bitcnt_q[63:32];
        widx_d        = sha1mh_pkg::LEN_LO_IDX;
        state_d       = sha1mh_pkg::ST_LEN_LO;
      end
      sha1mh_pkg::ST_LEN_LO: begin
        ctrl.sched_we = 1'b1;
        sched_wdata   = bitcnt_q[31:0];
        widx_d        = 4'd0;
        cnt_d         = 3'd0;
        ret_d         = sha1mh_pkg::ST_DIG_RD;
        state_d       = sha1mh_pkg::ST_LOAD;
      end
      sha1mh_pkg::ST_LOAD: begin
        // Read chaining values one per cycle, push each into the working vars.
        ch_re         = (cnt_q != sha1mh_pkg::NUM_DIG);
        ctrl.var_push = (cnt_q != 3'd0);
        if (cnt_q == sha1mh_pkg::NUM_DIG) begin
          ctrl.sched_re   = 1'b1;
          ctrl.sched_addr = 4'd0;
          rnd_d           = 7'd0;
          state_d         = sha1mh_pkg::ST_ROUND;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      sha1mh_pkg::ST_ROUND: begin
        ctrl.round_en = 1'b1;
        // Prefetch the block word for the next round while that is one of rounds 1 to 15.
        if (rnd_q < 7'd15) begin
          ctrl.sched_re   = 1'b1;
          ctrl.sched_addr = 4'(rnd_q[3:0] + 4'd1);
        end
        if (rnd_q == sha1mh_pkg::LAST_RND) begin
          cnt_d   = 3'd0;
          state_d = sha1mh_pkg::ST_UPDATE;
        end else begin
          rnd_d = rnd_q + 7'd1;
        end
      end
      sha1mh_pkg::ST_UPDATE: begin
        // Read entry n while writing back entry n-1 plus its working variable.
        ch_re         = (cnt_q != sha1mh_pkg::NUM_DIG);
        ch_we         = (cnt_q != 3'd0);
        ctrl.var_push = (cnt_q != 3'd0);
        if (cnt_q == sha1mh_pkg::NUM_DIG) begin
          fresh_d = 1'b0;
          cnt_d   = 3'd0;
          state_d = ret_q;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      sha1mh_pkg::ST_DIG_RD: begin
        ch_re   = 1'b1;
        state_d = sha1mh_pkg::ST_DIG_OUT;
      end
      sha1mh_pkg::ST_DIG_OUT: begin
        if (!ov_q || m_axis_tready_i) begin
          ov_d    = 1'b1;
          odata_d = ch_rd_q;
          oidx_d  = cnt_q;
          olast_d = (cnt_q == sha1mh_pkg::LAST_DIG);
          if (cnt_q == sha1mh_pkg::LAST_DIG) begin
            // Back to the initial chaining values for the next message.
            fresh_d  = 1'b1;
            bitcnt_d = 64'h0;
            cnt_d    = 3'd0;
            state_d  = sha1mh_pkg::ST_IDLE;
          end else begin
            cnt_d   = cnt_q + 3'd1;
            state_d = sha1mh_pkg::ST_DIG_RD;
          end
        end
      end
      default: begin
        state_d = sha1mh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sha1mh_pkg::ST_IDLE;
      ret_q    <= sha1mh_pkg::ST_IDLE;
      widx_q   <= 4'd0;
      cnt_q    <= 3'd0;
      rnd_q    <= 7'd0;
      fresh_q  <= 1'b1;
      bitcnt_q <= 64'h0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      widx_q   <= widx_d;
      cnt_q    <= cnt_d;
      rnd_q    <= rnd_d;
      fresh_q  <= fresh_d;
      bitcnt_q <= bitcnt_d;
      ov_q     <= ov_d;
    end
  end

  // Output payload holds while the receiver stalls.
  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
    oidx_q  <= oidx_d;
    olast_q <= olast_d;
  end

  always_ff @(posedge clk_i) begin
    if (ch_we) begin
      chain_mem_q[ch_waddr] <= ch_wdata;
    end
    if (ch_re) begin
      ch_rd_q <= chain_mem_q[ch_raddr];
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {5'h00, oidx_q, odata_q};
  assign m_axis_tlast_o  = olast_q;

endmodule

`default_nettype wire
